FILE: rtl/capture_header_crlf_repair_check_macros.svh
// Assertion macros used by the checker file of the header repair block.
`ifndef CAPTURE_HEADER_CRLF_REPAIR_CHECK_MACROS_SVH
`define CAPTURE_HEADER_CRLF_REPAIR_CHECK_MACROS_SVH
// Property checked on every clock edge outside reset.
`define CRLF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define CRLF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`endif

FILE: rtl/crlf_pkg.sv
// Types, constants and header decode functions of the header repair block.
package crlf_pkg;
   localparam logic [31:0] DAY_SECONDS = 32'd86400;
   localparam logic [31:0] MAX_USEC    = 32'd1000000;
   localparam logic [31:0] MAX_NSEC    = 32'd1000000000;
   localparam logic [31:0] MAX_LEN     = 32'd65535;
   localparam logic [31:0] MIN_LEN     = 32'd10;
   localparam logic [7:0]  CR_BYTE     = 8'h0D;
   localparam logic [7:0]  LF_BYTE     = 8'h0A;
   localparam int          HDR_BYTES   = 16;
   localparam int          IN_BYTES    = 32;

   localparam logic [1:0] WORD_SEC  = 2'd0;
   localparam logic [1:0] WORD_FRAC = 2'd1;
   localparam logic [1:0] WORD_INCL = 2'd2;
   localparam logic [1:0] WORD_ORIG = 2'd3;

   localparam logic REG_BYTE_ORDER = 1'b0;
   localparam logic REG_NS_MODE    = 1'b1;

   typedef struct packed {
      logic [63:0] window_bytes_lo;
      logic [63:0] window_bytes_mid;
      logic [63:0] window_bytes_hi;
      logic [63:0] window_bytes_top;
      logic [31:0] prior_seconds;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [2:0]  removed_count;
      logic [31:0] ts_seconds;
      logic [31:0] ts_fraction;
      logic [15:0] included_length;
      logic [15:0] original_length;
   } rsp_type;

   // One classified word waiting between front and back.
   typedef struct packed {
      logic [IN_BYTES*8-1:0] window;
      logic [31:0]           prior;
      logic                  quick_ok;
   } entry_type;

   function automatic logic [31:0] hdr_word(logic [HDR_BYTES*8-1:0] hdr, logic [1:0] idx,
                                            logic order);
      logic [31:0] w;
      w = hdr[32*idx +: 32];
      return order ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
   endfunction

   function automatic logic hdr_plausible(logic [HDR_BYTES*8-1:0] hdr, logic [31:0] prior,
                                          logic order, logic ns_mode);
      logic [31:0] sec;
      logic [31:0] frac;
      logic [31:0] incl;
      logic [31:0] orig;
      logic [31:0] upper;
      logic [31:0] lower;
      logic        ok;
      sec   = hdr_word(hdr, WORD_SEC, order);
      frac  = hdr_word(hdr, WORD_FRAC, order);
      incl  = hdr_word(hdr, WORD_INCL, order);
      orig  = hdr_word(hdr, WORD_ORIG, order);
      upper = prior + DAY_SECONDS;
      lower = prior - DAY_SECONDS;
      ok = (incl >= MIN_LEN) && (orig >= MIN_LEN) && (incl <= MAX_LEN) && (orig <= MAX_LEN)
           && (incl <= orig);
      if (prior != 32'd0 && sec > upper) ok = 1'b0;
      if (prior >= DAY_SECONDS && sec < lower) ok = 1'b0;
      if (ns_mode ? (frac > MAX_NSEC) : (frac > MAX_USEC)) ok = 1'b0;
      return ok;
   endfunction
endpackage

FILE: rtl/crlf_front.sv
// Front part: forms a queue word from the request and pre-checks its header.
module crlf_front (
   input  crlf_pkg::req_type   req,
   input  logic                byte_order,
   input  logic                ns_mode,
   output crlf_pkg::entry_type entry
);
   import crlf_pkg::*;

   logic [IN_BYTES*8-1:0] win;

   assign win = {req.window_bytes_top, req.window_bytes_hi, req.window_bytes_mid,
                 req.window_bytes_lo};

   always_comb begin
      entry.window   = win;
      entry.prior    = req.prior_seconds;
      entry.quick_ok = hdr_plausible(win[HDR_BYTES*8-1:0], req.prior_seconds, byte_order,
                                     ns_mode);
   end
endmodule

FILE: rtl/crlf_queue.sv
// Two-word queue between the front and the search engine.
module crlf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  crlf_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output crlf_pkg::entry_type head
);
   import crlf_pkg::*;

   entry_type   slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

FILE: rtl/crlf_search.sv
// Back part: depth-first CR deletion search with a window stack in memory.
module crlf_search #(
   parameter int WINDOW_BYTES = 32,
   parameter int STOP_SIZE    = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_order,
   input  logic                ns_mode,
   input  logic                q_valid,
   input  crlf_pkg::entry_type q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   output crlf_pkg::rsp_type   rsp
);
   import crlf_pkg::*;

   localparam int DMAX = (WINDOW_BYTES > STOP_SIZE) ? WINDOW_BYTES - STOP_SIZE : 1;
   localparam int DW   = $clog2(DMAX + 1);
   localparam int AW   = (DMAX > 1) ? $clog2(DMAX) : 1;

   typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_BACK, S_POP} state_type;

   state_type                      state_ff;
   logic [WINDOW_BYTES-1:0][7:0]   cur_ff;
   logic [4:0]                     pos_ff;
   logic [DW-1:0]                  depth_ff;
   logic [31:0]                    prior_ff;
   logic                           quick_ff;
   logic [WINDOW_BYTES-1:0][7:0]   stk_win [DMAX];
   logic [4:0]                     stk_pos [DMAX];
   logic [WINDOW_BYTES-1:0][7:0]   rd_win_ff;
   logic [4:0]                     rd_pos_ff;
   logic                           rsp_valid_ff;
   rsp_type                        rsp_ff;

   logic [WINDOW_BYTES-1:0][7:0]   load_win;
   logic [WINDOW_BYTES-1:0][7:0]   del_win;
   logic [HDR_BYTES*8-1:0]         hdr;
   logic                           ok;
   logic                           check_ok;
   logic                           is_pair;
   logic [2:0]                     sat_count;
   logic [31:0]                    incl_word;
   logic [31:0]                    orig_word;
   rsp_type                        hit;

   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      for (int k = 0; k < WINDOW_BYTES; k++) begin
         load_win[k] = (k < IN_BYTES) ? q_head.window[8*k +: 8] : 8'd0;
         if (k < int'(pos_ff)) del_win[k] = cur_ff[k];
         else if (k + 1 < WINDOW_BYTES) del_win[k] = cur_ff[k+1];
         else del_win[k] = 8'd0;
      end
      hdr     = cur_ff[HDR_BYTES-1:0];
      ok      = hdr_plausible(hdr, prior_ff, byte_order, ns_mode);
      // The unmodified window was already checked by the front.
      check_ok = (depth_ff == '0) ? quick_ff : ok;
      is_pair = (cur_ff[pos_ff[3:0]] == CR_BYTE) &&
                (cur_ff[{1'b0, pos_ff[3:0]} + 5'd1] == LF_BYTE);
      sat_count = (depth_ff > DW'(7)) ? 3'd7 : 3'(depth_ff);
      incl_word = hdr_word(hdr, WORD_INCL, byte_order);
      orig_word = hdr_word(hdr, WORD_ORIG, byte_order);
      hit.found           = 1'b1;
      hit.removed_count   = sat_count;
      hit.ts_seconds      = hdr_word(hdr, WORD_SEC, byte_order);
      hit.ts_fraction     = hdr_word(hdr, WORD_FRAC, byte_order);
      hit.included_length = incl_word[15:0];
      hit.original_length = orig_word[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cur_ff   <= load_win;
                  prior_ff <= q_head.prior;
                  quick_ff <= q_head.quick_ok;
                  depth_ff <= '0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               pos_ff <= 5'd0;
               if (check_ok) begin
                  rsp_ff       <= hit;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if (WINDOW_BYTES - int'(depth_ff) <= STOP_SIZE) begin
                  state_ff <= S_BACK;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (pos_ff == 5'(HDR_BYTES)) begin
                  state_ff <= S_BACK;
               end else if (is_pair) begin
                  stk_win[depth_ff[AW-1:0]] <= cur_ff;
                  stk_pos[depth_ff[AW-1:0]] <= pos_ff + 5'd1;
                  cur_ff   <= del_win;
                  depth_ff <= depth_ff + DW'(1);
                  state_ff <= S_CHECK;
               end else begin
                  pos_ff <= pos_ff + 5'd1;
               end
            end
            S_BACK: begin
               if (depth_ff == '0) begin
                  rsp_ff       <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  rd_win_ff <= stk_win[AW'(depth_ff - DW'(1))];
                  rd_pos_ff <= stk_pos[AW'(depth_ff - DW'(1))];
                  depth_ff  <= depth_ff - DW'(1);
                  state_ff  <= S_POP;
               end
            end
            S_POP: begin
               cur_ff   <= rd_win_ff;
               pos_ff   <= rd_pos_ff;
               state_ff <= S_SCAN;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: rtl/capture_header_crlf_repair_check.sv
// Top level of the capture header check with CR-before-LF repair search.
// A plausible header is taken from the queue in idle and checked in the check state,
// which registers its result and strobe; the queue meanwhile takes further words.
// A repair search runs per node a check step, scan steps over the header positions,
// a step to end the scan, and back and pop states; busy rises once the queue holds two.
// Synchronous reset empties the queue, idles the engine and zeroes both registers.
module capture_header_crlf_repair_check #(
   parameter int WINDOW_BYTES = 32,
   parameter int STOP_SIZE    = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  crlf_pkg::req_type req,
   output logic              rsp_valid,
   output crlf_pkg::rsp_type rsp,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic              csr_wdata
);
   import crlf_pkg::*;

   logic      byte_order_ff;
   logic      ns_mode_ff;
   entry_type front_word;
   entry_type head_word;
   logic      q_full;
   logic      q_valid;
   logic      q_pop;

   // Users write the configuration registers only while the block is idle; not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_order_ff <= 1'b0;
         ns_mode_ff    <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == REG_BYTE_ORDER) byte_order_ff <= csr_wdata;
         if (csr_index == REG_NS_MODE) ns_mode_ff <= csr_wdata;
      end
   end

   assign busy = q_full;

   // The front classifies each accepted word and hands it to the queue.
   crlf_front u_front (
      .req        (req),
      .byte_order (byte_order_ff),
      .ns_mode    (ns_mode_ff),
      .entry      (front_word)
   );

   crlf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (start && !q_full),
      .push_data (front_word),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (head_word)
   );

   // The back runs the search and drives the result strobe for one cycle.
   crlf_search #(
      .WINDOW_BYTES (WINDOW_BYTES),
      .STOP_SIZE    (STOP_SIZE)
   ) u_search (
      .clock      (clock),
      .reset      (reset),
      .byte_order (byte_order_ff),
      .ns_mode    (ns_mode_ff),
      .q_valid    (q_valid),
      .q_head     (head_word),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );
endmodule

FILE: rtl/crlf_check.sv
// Port-level checker of the header repair block and its bind.
`include "capture_header_crlf_repair_check_macros.svh"
module crlf_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input crlf_pkg::rsp_type rsp
);
   import crlf_pkg::*;

   logic hit_len_ok;

   assign hit_len_ok = (rsp.included_length >= MIN_LEN[15:0]) &&
                       (rsp.included_length <= rsp.original_length);

   `CRLF_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy && !rsp_valid, "busy or strobe after reset")
   `CRLF_ASSERT(a_miss_zero, rsp_valid && !rsp.found |-> rsp == '0, "miss word not all zero")
   `CRLF_ASSERT(a_hit_len, rsp_valid && rsp.found |-> hit_len_ok, "found header has bad lengths")
   `CRLF_ASSERT(a_one_strobe, rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
   `CRLF_ASSERT(a_busy_rise, !busy && !start |=> !busy, "busy rose with no word accepted")
endmodule

bind capture_header_crlf_repair_check crlf_check u_crlf_check (.*);

FILE: dv/capture_header_crlf_repair_check_tb.sv
// Self-checking testbench for the capture header check with CR-before-LF repair search.
module capture_header_crlf_repair_check_tb;
   import crlf_pkg::*;

   // Holds the predicted header decodes in order and compares each returned word.
   class header_scoreboard;
      rsp_type pending[$];
      int      mismatches;
      int      checked;
      int      found_count;
      int      repaired_count;

      function void note_input(rsp_type predicted);
         pending.push_back(predicted);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch("result word arrived with nothing expected", 0, 0);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.found) found_count++;
         if (want.removed_count != 0) repaired_count++;
         if (got.found !== want.found)
            report_mismatch("found", got.found, want.found);
         if (got.removed_count !== want.removed_count)
            report_mismatch("removed_count", got.removed_count, want.removed_count);
         if (got.ts_seconds !== want.ts_seconds)
            report_mismatch("ts_seconds", got.ts_seconds, want.ts_seconds);
         if (got.ts_fraction !== want.ts_fraction)
            report_mismatch("ts_fraction", got.ts_fraction, want.ts_fraction);
         if (got.included_length !== want.included_length)
            report_mismatch("included_length", got.included_length, want.included_length);
         if (got.original_length !== want.original_length)
            report_mismatch("original_length", got.original_length, want.original_length);
      endfunction

      function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("mismatch on %s: got %h, expected %h", what, got, want);
      endfunction
   endclass

   localparam int WINDOW_BYTES = 32;
   localparam int STOP_SIZE    = 25;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req = '0;
   logic    rsp_valid;
   rsp_type rsp;
   logic    csr_we = 1'b0;
   logic    csr_index = 1'b0;
   logic    csr_wdata = 1'b0;

   // The testbench's own copy of the two configuration registers.
   logic    cfg_swapped = 1'b0;
   logic    cfg_nanosec = 1'b0;

   header_scoreboard board = new();
   int      words_sent = 0;
   bit      quiet_stretch = 1'b0;

   always #6 clock = ~clock;

   capture_header_crlf_repair_check #(
      .WINDOW_BYTES(WINDOW_BYTES),
      .STOP_SIZE(STOP_SIZE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req(req),
      .rsp_valid(rsp_valid),
      .rsp(rsp),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Results cannot be held off, so every strobed word is checked at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp);
   end

   // Reads one 32-bit header word at byte offset pos, honoring the byte order setting.
   function automatic logic [31:0] read_header_word(logic [7:0] bytes[WINDOW_BYTES], int pos);
      if (cfg_swapped)
         return {bytes[pos], bytes[pos+1], bytes[pos+2], bytes[pos+3]};
      return {bytes[pos+3], bytes[pos+2], bytes[pos+1], bytes[pos]};
   endfunction

   // Checks the header at the front of a window against the prior timestamp.
   function automatic bit header_fits(logic [7:0] bytes[WINDOW_BYTES], logic [31:0] prior,
                                      output rsp_type fields);
      logic [31:0] sec;
      logic [31:0] frac;
      logic [31:0] incl;
      logic [31:0] orig;
      logic [31:0] upper;
      sec  = read_header_word(bytes, 0);
      frac = read_header_word(bytes, 4);
      incl = read_header_word(bytes, 8);
      orig = read_header_word(bytes, 12);
      upper = prior + 32'd86400;
      fields = '0;
      fields.found           = 1'b1;
      fields.ts_seconds      = sec;
      fields.ts_fraction     = frac;
      fields.included_length = incl[15:0];
      fields.original_length = orig[15:0];
      if (incl < 10 || orig < 10 || incl > 65535 || orig > 65535 || incl > orig) return 0;
      if (prior != 0 && sec > upper) return 0;
      if (prior >= 32'd86400 && sec < prior - 32'd86400) return 0;
      if (cfg_nanosec ? (frac > 32'd1000000000) : (frac > 32'd1000000)) return 0;
      return 1;
   endfunction

   // Depth-first search over deletions of a CR that sits just before an LF.
   // Returns the number of deletions, or -1 when no arrangement gives a header.
   function automatic int repair_depth(logic [7:0] bytes[WINDOW_BYTES], int len,
                                       logic [31:0] prior, output rsp_type fields);
      logic [7:0] shorter[WINDOW_BYTES];
      rsp_type    inner;
      int         r;
      if (header_fits(bytes, prior, fields)) return 0;
      if (len <= STOP_SIZE) return -1;
      for (int i = 0; i < 16; i++) begin
         if (i + 1 < len && bytes[i] == CR_BYTE && bytes[i+1] == LF_BYTE) begin
            for (int k = 0; k < WINDOW_BYTES; k++)
               shorter[k] = (k >= len - 1) ? 8'h00 : (k < i ? bytes[k] : bytes[k+1]);
            r = repair_depth(shorter, len - 1, prior, inner);
            if (r >= 0) begin
               fields = inner;
               return r + 1;
            end
         end
      end
      return -1;
   endfunction

   function automatic rsp_type predict_header(req_type word);
      logic [7:0]   bytes[WINDOW_BYTES];
      logic [255:0] flat;
      rsp_type      fields;
      int           r;
      flat = {word.window_bytes_top, word.window_bytes_hi, word.window_bytes_mid,
              word.window_bytes_lo};
      for (int k = 0; k < WINDOW_BYTES; k++) bytes[k] = (k < 32) ? flat[8*k +: 8] : 8'h00;
      r = repair_depth(bytes, WINDOW_BYTES, word.prior_seconds, fields);
      if (r < 0) return '0;
      fields.removed_count = (r > 7) ? 3'd7 : r[2:0];
      return fields;
   endfunction

   // Places a 32-bit value as four window bytes in the current byte order.
   function automatic logic [31:0] encode_word(logic [31:0] v);
      return cfg_swapped ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
   endfunction

   // Builds a window whose header is plausible for the given prior unless its seconds wrap.
   function automatic req_type build_good_window(logic [31:0] prior);
      req_type     word;
      logic [31:0] sec;
      logic [31:0] frac;
      logic [31:0] incl;
      logic [31:0] orig;
      incl = $urandom_range(10, 65535);
      orig = $urandom_range(incl, 65535);
      frac = cfg_nanosec ? $urandom_range(0, 1000000000) : $urandom_range(0, 1000000);
      sec  = (prior == 0) ? $urandom() : prior + $urandom_range(0, 2 * 86400) - 86400;
      word.window_bytes_lo  = {encode_word(frac), encode_word(sec)};
      word.window_bytes_mid = {encode_word(orig), encode_word(incl)};
      word.window_bytes_hi  = {$urandom(), $urandom()};
      word.window_bytes_top = {$urandom(), $urandom()};
      word.prior_seconds    = prior;
      return word;
   endfunction

   // Inserts CR bytes ahead of LF bytes of a good header, the way a text-mode
   // transfer corrupts it. Positions are chosen so the insertions land before
   // an existing LF or a freshly planted one.
   function automatic req_type corrupt_with_cr(req_type clean, int count);
      logic [255:0] flat;
      logic [7:0]   bytes[40];
      int           len;
      int           pos;
      flat = {clean.window_bytes_top, clean.window_bytes_hi, clean.window_bytes_mid,
              clean.window_bytes_lo};
      for (int k = 0; k < 32; k++) bytes[k] = flat[8*k +: 8];
      len = 32;
      for (int n = 0; n < count; n++) begin
         pos = $urandom_range(0, 14);
         if ($urandom_range(0, 1)) bytes[pos] = LF_BYTE;
         for (int k = 39; k > pos; k--) bytes[k] = bytes[k-1];
         bytes[pos] = CR_BYTE;
         if (bytes[pos+1] != LF_BYTE) bytes[pos+1] = LF_BYTE;
      end
      for (int k = 0; k < 32; k++) flat[8*k +: 8] = bytes[k];
      {clean.window_bytes_top, clean.window_bytes_hi, clean.window_bytes_mid,
       clean.window_bytes_lo} = flat;
      return clean;
   endfunction

   function automatic req_type random_window();
      req_type word;
      word.window_bytes_lo  = {$urandom(), $urandom()};
      word.window_bytes_mid = {$urandom(), $urandom()};
      word.window_bytes_hi  = {$urandom(), $urandom()};
      word.window_bytes_top = {$urandom(), $urandom()};
      word.prior_seconds    = $urandom();
      return word;
   endfunction

   function automatic logic [31:0] random_prior();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return $urandom_range(1, 86399);
         2: return 32'd86400;
         3: return 32'hFFFF_FFFF - $urandom_range(0, 86400);
         default: return $urandom();
      endcase
   endfunction

   // Hands one word to the block: waits for busy low at an edge, then holds start
   // for exactly that edge. Start is only lowered when no word follows at once.
   task automatic send_word(req_type word);
      while ($urandom_range(0, 99) < 10 && !quiet_stretch) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req   <= word;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_input(predict_header(word));
      words_sent++;
   endtask

   task automatic end_burst();
      start <= 1'b0;
   endtask

   // Lets every pending result drain, then a margin for any work still in flight.
   task automatic drain();
      end_burst();
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Register writes happen only while the block is idle.
   task automatic write_register(logic index, logic value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (index == REG_BYTE_ORDER) cfg_swapped = value;
      else cfg_nanosec = value;
   endtask

   task automatic directed_words();
      req_type word;
      // Field extremes: all zeros, all ones.
      send_word('0);
      word = '1;
      send_word(word);
      // Length boundaries around a valid header.
      word = build_good_window(32'd0);
      word.window_bytes_mid = {encode_word(32'd10), encode_word(32'd10)};
      send_word(word);
      word.window_bytes_mid = {encode_word(32'd65535), encode_word(32'd65535)};
      send_word(word);
      word.window_bytes_mid = {encode_word(32'd9), encode_word(32'd9)};
      send_word(word);
      word.window_bytes_mid = {encode_word(32'd65536), encode_word(32'd100)};
      send_word(word);
      word.window_bytes_mid = {encode_word(32'd20), encode_word(32'd21)};
      send_word(word);
      // Sub-second limits in both units.
      word = build_good_window(32'd0);
      word.window_bytes_lo[63:32] = encode_word(32'd1000000);
      send_word(word);
      word.window_bytes_lo[63:32] = encode_word(32'd1000001);
      send_word(word);
      word.window_bytes_lo[63:32] = encode_word(32'd1000000000);
      send_word(word);
      // Seconds exactly at and beyond one day from the prior, with wraparound.
      word = build_good_window(32'd100000);
      word.window_bytes_lo[31:0] = encode_word(32'd100000 + 32'd86400);
      send_word(word);
      word.window_bytes_lo[31:0] = encode_word(32'd100000 + 32'd86401);
      send_word(word);
      word.window_bytes_lo[31:0] = encode_word(32'd100000 - 32'd86400);
      send_word(word);
      word.window_bytes_lo[31:0] = encode_word(32'd100000 - 32'd86401);
      send_word(word);
      word = build_good_window(32'hFFFF_FFF0);
      word.window_bytes_lo[31:0] = encode_word(32'd5);
      send_word(word);
      word = build_good_window(32'd86399);
      word.window_bytes_lo[31:0] = encode_word(32'd0);
      send_word(word);
      // Repairs of growing depth, including the deepest one allowed.
      for (int n = 1; n <= 7; n++) send_word(corrupt_with_cr(build_good_window(32'd0), n));
      // A search that cannot succeed: CR LF pairs everywhere in the header area.
      word = '0;
      for (int k = 0; k < 8; k++) word.window_bytes_lo[8*k +: 8] = k[0] ? LF_BYTE : CR_BYTE;
      for (int k = 0; k < 8; k++) word.window_bytes_mid[8*k +: 8] = k[0] ? LF_BYTE : CR_BYTE;
      send_word(word);
   endtask

   task automatic random_words(int count);
      int roll;
      logic [31:0] prior;
      for (int n = 0; n < count; n++) begin
         // A stretch with no idling in the middle of each phase.
         quiet_stretch = (n >= count / 3) && (n < count / 2);
         roll  = $urandom_range(0, 99);
         prior = random_prior();
         if (roll < 55) send_word(build_good_window(prior));
         else if (roll < 80)
            send_word(corrupt_with_cr(build_good_window(prior), $urandom_range(1, 7)));
         else send_word(random_window());
         // Once per phase, hold off until the block has nothing outstanding.
         if (n == count / 4) begin
            end_burst();
            @(posedge clock);
            while (board.pending.size() != 0) @(posedge clock);
         end
      end
      quiet_stretch = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_words();
      drain();
      // Four phases cover every register setting, both extremes included.
      for (int phase = 0; phase < 4; phase++) begin
         write_register(REG_BYTE_ORDER, phase[0]);
         write_register(REG_NS_MODE, phase[1]);
         if (phase == 3) directed_words();
         random_words(220);
         drain();
      end

      $display("Checked %0d words: %0d headers found, %0d of them after CR deletion.",
               board.checked, board.found_count, board.repaired_count);
      $display("Both byte orders and both sub-second units were exercised.");
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // A window packed with CR LF pairs walks tens of thousands of search nodes; this bound
   // covers every word of the run needing such a long walk.
   initial begin
      repeat (1000) #100000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/crlf_pkg.sv
rtl/crlf_front.sv
rtl/crlf_queue.sv
rtl/crlf_search.sv
rtl/capture_header_crlf_repair_check.sv
rtl/crlf_check.sv
dv/capture_header_crlf_repair_check_tb.sv
